/* rtl/ltcg_pkg.sv */
// ----------------------------------------------------------------------------
// ltcg_pkg: shared types and constants of the LCD text cursor command generator
// Request modes, controller command bytes, control characters and the result
// record that travels through the output queue.
// ----------------------------------------------------------------------------
package ltcg_pkg;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_HOME  = 2'd3
  } mode_e;

  // Controller command bytes.
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;

  // Control characters handled by a put.
  localparam logic [7:0] CHAR_BS = 8'h08;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Default display geometry.
  localparam int unsigned DEF_COLUMNS = 8;
  localparam int unsigned DEF_ROWS    = 2;

  // Width of the column field of a request.
  localparam int unsigned COL_IN_W = 3;

  // One bus write.
  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_value;
    logic       last;
  } result_t;

endpackage

/* rtl/ltcg_ifs.sv */
// ----------------------------------------------------------------------------
// ltcg_ifs: request and result channels of the LCD text cursor command generator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ltcg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic [2:0] column;
  logic       row;

  modport source (output valid, output mode, output char_code, output column,
                  output row, input ready);
  modport sink (input valid, input mode, input char_code, input column,
                input row, output ready);
endinterface

interface ltcg_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] byte_value;
  logic       last;

  modport source (output valid, output is_data, output byte_value, output last,
                  input ready);
  modport sink (input valid, input is_data, input byte_value, input last,
                output ready);
endinterface

/* rtl/lcd_text_cursor_command_gen.sv */
// ----------------------------------------------------------------------------
// lcd_text_cursor_command_gen: terminal-style text output for a character LCD
// Output: the bus writes of a request are registered in the output queue and shown in order.
// Throughput: one request per cycle while the result side is ready and each gives
//   one write; a request that gives two writes (printable character at the last
//   column) sends both through the output in turn, since the result channel moves one write per cycle.
// Reset: rst_ni clears the cursor to column 0, row 0 and empties the queue.
// ----------------------------------------------------------------------------
module lcd_text_cursor_command_gen #(
  parameter int unsigned COLUMNS = ltcg_pkg::DEF_COLUMNS,
  parameter int unsigned ROWS    = ltcg_pkg::DEF_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ltcg_in_if.sink           req_i,
  ltcg_out_if.source        rsp_o
);

  // Cursor column needs enough bits for COLUMNS-1; the row is one bit since
  // the display has at most two rows.
  localparam int unsigned ColW = $clog2(COLUMNS);
  localparam logic [ColW-1:0] ColMax = ColW'(COLUMNS - 1);
  localparam logic            RowMax = 1'(ROWS - 1);
  localparam int unsigned QDepth = 3;
  localparam int unsigned COL_IN_BITS = ltcg_pkg::COL_IN_W;

  // Cursor state.
  logic [ColW-1:0] col_q, col_d;
  logic            row_q, row_d;

  // Output queue: entry 0 is presented on the result channel. Three entries
  // let a two-write request enter while one earlier write still waits.
  ltcg_pkg::result_t q_q [QDepth];
  ltcg_pkg::result_t q_d [QDepth];
  logic [1:0]        cnt_q, cnt_d;

  // Results of the request being transferred this cycle.
  ltcg_pkg::result_t r0, r1;
  logic              two;

  logic push, pop;
  logic [1:0] base;

  // Set-address command: 0x80 | row << 6 | column.
  function automatic logic [7:0] addr_cmd(input logic [ColW-1:0] c, input logic r);
    logic [7:0] cmd;
    cmd = ltcg_pkg::CMD_SET_ADDR | {1'b0, r, 6'(c)};
    return cmd;
  endfunction

  // The request side is ready while at most one write is queued, so a
  // two-write request always finds room. Ready does not depend on the
  // result side's ready within the cycle.
  assign req_i.ready = (cnt_q <= 2'd1);
  assign push        = req_i.valid && req_i.ready;
  assign pop         = rsp_o.valid && rsp_o.ready;

  assign rsp_o.valid      = (cnt_q != 2'd0);
  assign rsp_o.is_data    = q_q[0].is_data;
  assign rsp_o.byte_value = q_q[0].byte_value;
  assign rsp_o.last       = q_q[0].last;

  // Request decode: new cursor position and up to two bus writes.
  always_comb begin
    logic [COL_IN_BITS-1:0] red;
    red   = req_i.column;
    col_d = col_q;
    row_d = row_q;
    two   = 1'b0;
    r0    = '{is_data: 1'b0, byte_value: ltcg_pkg::CMD_HOME, last: 1'b1};
    r1    = '{is_data: 1'b0, byte_value: ltcg_pkg::CMD_HOME, last: 1'b1};

    unique case (ltcg_pkg::mode_e'(req_i.mode))
      ltcg_pkg::MODE_SET: begin
        // Reduce the requested column below COLUMNS by repeated subtraction;
        // three steps cover a three-bit column for any COLUMNS of two or more.
        for (int i = 0; i < 3; i++) begin
          if (int'(red) >= int'(COLUMNS)) begin
            red = red - COL_IN_BITS'(COLUMNS);
          end
        end
        col_d = ColW'(red);
        row_d = (ROWS > 1) ? req_i.row : 1'b0;
        r0.byte_value = addr_cmd(col_d, row_d);
      end
      ltcg_pkg::MODE_CLEAR: begin
        col_d = '0;
        row_d = 1'b0;
        r0.byte_value = ltcg_pkg::CMD_CLEAR;
      end
      ltcg_pkg::MODE_HOME: begin
        col_d = '0;
        row_d = 1'b0;
        r0.byte_value = ltcg_pkg::CMD_HOME;
      end
      ltcg_pkg::MODE_PUT: begin
        priority if (req_i.char_code == ltcg_pkg::CHAR_BS) begin
          // Backspace steps back, wrapping to the end of the previous row and
          // from the first cell to the last cell.
          if (col_q != '0) begin
            col_d = col_q - 1'b1;
          end else begin
            col_d = ColMax;
            row_d = (row_q != 1'b0) ? 1'b0 : RowMax;
          end
          r0.byte_value = addr_cmd(col_d, row_d);
        end else if (req_i.char_code == ltcg_pkg::CHAR_CR) begin
          col_d = '0;
          r0.byte_value = addr_cmd(col_d, row_d);
        end else if (req_i.char_code == ltcg_pkg::CHAR_LF) begin
          col_d = '0;
          row_d = (row_q < RowMax) ? 1'b1 : 1'b0;
          r0.byte_value = addr_cmd(col_d, row_d);
        end else begin
          // Printable character: data write, then advance the cursor. At the
          // last column the cursor moves to the next row and a set-address
          // command follows the data write.
          r0.is_data    = 1'b1;
          r0.byte_value = req_i.char_code;
          if (col_q < ColMax) begin
            col_d = col_q + 1'b1;
          end else begin
            col_d = '0;
            row_d = (row_q < RowMax) ? 1'b1 : 1'b0;
            r0.last = 1'b0;
            two = 1'b1;
            r1.byte_value = addr_cmd(col_d, row_d);
          end
        end
      end
      default: begin
        col_d = col_q;
      end
    endcase
  end

  // Queue bookkeeping: shift out on a result transfer, append on a request
  // transfer behind whatever remains.
  always_comb begin
    base = cnt_q - {1'b0, pop};
    q_d  = q_q;
    if (pop) begin
      q_d[0] = q_q[1];
      q_d[1] = q_q[2];
    end
    if (push) begin
      q_d[base] = r0;
      if (two) begin
        q_d[base + 2'd1] = r1;
      end
    end
    cnt_d = base + {1'b0, push} + {1'b0, push && two};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

/* rtl/ltcg_checker.sv */
// ----------------------------------------------------------------------------
// ltcg_checker: port-level checks of the LCD text cursor command generator
// Watches both channels and flags misordered or missing bus writes.
// ----------------------------------------------------------------------------
module ltcg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_mode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_is_data_i,
  input logic [7:0] out_byte_value_i,
  input logic       out_last_i
);

  // A request transferred into an empty output always shows a write next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i) |=> out_valid_i)
    else $error("request transfer produced no bus write");

  // A clear request into an empty output shows the clear command, last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i &&
     in_mode_i == ltcg_pkg::MODE_CLEAR)
    |=> (!out_is_data_i && out_last_i && out_byte_value_i == ltcg_pkg::CMD_CLEAR))
    else $error("clear request gave a wrong bus write");

  // A data write that is not last is directly followed by a set-address command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_is_data_i && !out_last_i)
    |=> (out_valid_i && !out_is_data_i && out_byte_value_i[7] && out_last_i))
    else $error("wrapped data write not followed by set-address command");

  // A stalled bus write holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i)
    |=> (out_valid_i && $stable(out_byte_value_i) && $stable(out_is_data_i) &&
         $stable(out_last_i)))
    else $error("stalled bus write changed");

endmodule

bind lcd_text_cursor_command_gen ltcg_checker u_ltcg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .in_mode_i        (req_i.mode),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .out_is_data_i    (rsp_o.is_data),
  .out_byte_value_i (rsp_o.byte_value),
  .out_last_i       (rsp_o.last)
);

/* tb/sv/lcd_text_cursor_command_gen_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_text_cursor_command_gen_tb: self-checking bench for the LCD text writer
// Sends terminal-style requests through the request channel, tracks the
// cursor with its own copy of the display state, and checks every bus write
// that leaves the result channel against the writes that this copy predicts.
// ----------------------------------------------------------------------------
module lcd_text_cursor_command_gen_tb;

  localparam int unsigned COLUMNS     = ltcg_pkg::DEF_COLUMNS;
  localparam int unsigned ROWS        = ltcg_pkg::DEF_ROWS;
  localparam int          CYCLE_LIMIT = 400_000;

  logic clk_i;
  logic rst_ni;

  ltcg_in_if  req ();
  ltcg_out_if rsp ();

  lcd_text_cursor_command_gen #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Free-running clock, 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Cursor as the bench expects the display to hold it. It follows the same
  // rules as the block: wrap at the row end, wrap from the last row to row 0,
  // and wrap backward from the first cell to the last cell.
  logic [2:0] cursor_col;
  logic       cursor_row;

  // Bus writes that have been predicted but have not left the block yet,
  // oldest first.
  ltcg_pkg::result_t pending_bus_writes[$];

  int fail_count;
  int cycle_count;

  // Percent chance per transfer of an idle burst on the request side, and per
  // cycle of a stall burst on the result side. The test tasks set these so
  // that some stretches run with gaps and stalls and some at full rate.
  int src_gap_pct;
  int sink_stall_pct;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Set-address command for the current cursor cell.
  function automatic logic [7:0] cursor_address();
    return ltcg_pkg::CMD_SET_ADDR | {1'b0, cursor_row, 3'b000, cursor_col};
  endfunction

  function automatic void push_write(input logic is_data, input logic [7:0] value,
                                     input logic is_last);
    ltcg_pkg::result_t w;
    w.is_data    = is_data;
    w.byte_value = value;
    w.last       = is_last;
    pending_bus_writes.push_back(w);
  endfunction

  // Column 0 of the next row; the last row wraps around to row 0.
  function automatic void advance_row();
    cursor_col = '0;
    if (int'(cursor_row) < ROWS - 1) begin
      cursor_row = cursor_row + 1'b1;
    end else begin
      cursor_row = '0;
    end
  endfunction

  // Works out the bus writes that one accepted request causes and moves the
  // cursor the way the display controller will see it moved.
  function automatic void predict_bus_writes(input ltcg_pkg::mode_e m,
                                             input logic [7:0] ch,
                                             input logic [2:0] col, input logic rw);
    case (m)
      ltcg_pkg::MODE_SET: begin
        // Out-of-range targets are reduced, then both stored and sent.
        cursor_col = 3'(int'(col) % COLUMNS);
        cursor_row = 1'(int'(rw) % ROWS);
        push_write(1'b0, cursor_address(), 1'b1);
      end
      ltcg_pkg::MODE_CLEAR: begin
        cursor_col = '0;
        cursor_row = '0;
        push_write(1'b0, ltcg_pkg::CMD_CLEAR, 1'b1);
      end
      ltcg_pkg::MODE_HOME: begin
        cursor_col = '0;
        cursor_row = '0;
        push_write(1'b0, ltcg_pkg::CMD_HOME, 1'b1);
      end
      default: begin
        if (ch == ltcg_pkg::CHAR_BS) begin
          // Backspace steps back one cell, across rows and from the first
          // cell around to the last one.
          if (cursor_col != 0) begin
            cursor_col = cursor_col - 1'b1;
          end else if (cursor_row != 0) begin
            cursor_col = 3'(COLUMNS - 1);
            cursor_row = cursor_row - 1'b1;
          end else begin
            cursor_col = 3'(COLUMNS - 1);
            cursor_row = 1'(ROWS - 1);
          end
          push_write(1'b0, cursor_address(), 1'b1);
        end else if (ch == ltcg_pkg::CHAR_CR) begin
          cursor_col = '0;
          push_write(1'b0, cursor_address(), 1'b1);
        end else if (ch == ltcg_pkg::CHAR_LF) begin
          advance_row();
          push_write(1'b0, cursor_address(), 1'b1);
        end else if (int'(cursor_col) < COLUMNS - 1) begin
          push_write(1'b1, ch, 1'b1);
          cursor_col = cursor_col + 1'b1;
        end else begin
          // The character fills the last column; the controller has to be
          // told where the next row starts, so a second write follows.
          push_write(1'b1, ch, 1'b0);
          advance_row();
          push_write(1'b0, cursor_address(), 1'b1);
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request and returns at the edge where it transfers. Valid is
  // left high on return, so back-to-back requests keep it high without a
  // drop; it goes low only when an idle burst starts or the run ends.
  task automatic send_request(input ltcg_pkg::mode_e m, input logic [7:0] ch,
                              input logic [2:0] col, input logic rw);
    int gap;
    gap = 0;
    if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
      gap = $urandom_range(1, 18);
    end
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.mode      <= m;
    req.char_code <= ch;
    req.column    <= col;
    req.row       <= rw;
    do @(posedge clk_i); while (!req.ready);
    predict_bus_writes(m, ch, col, rw);
  endtask

  // A character for running text: mostly printable ASCII, some control
  // characters, and now and then any byte at all.
  function automatic logic [7:0] text_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return 8'($urandom_range(8'h20, 8'h7E));
    end else if (pick < 75) begin
      return ltcg_pkg::CHAR_BS;
    end else if (pick < 82) begin
      return ltcg_pkg::CHAR_CR;
    end else if (pick < 90) begin
      return ltcg_pkg::CHAR_LF;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Any request at all: every mode and every value of every field.
  task automatic send_any_request();
    logic [7:0] ch;
    ch = ($urandom_range(0, 3) == 0) ? text_char() : 8'($urandom_range(0, 255));
    send_request(ltcg_pkg::mode_e'($urandom_range(0, 3)), ch, 3'($urandom_range(0, 7)),
                 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // Ready is pulled low in stall bursts that start at random.
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Every write that transfers is matched against the oldest prediction.
  // Inputs change only through nonblocking updates at the edge, so the values
  // read here are the ones that were stable before the edge.
  ltcg_pkg::result_t seen_write;
  ltcg_pkg::result_t want_write;

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      seen_write.is_data    = rsp.is_data;
      seen_write.byte_value = rsp.byte_value;
      seen_write.last       = rsp.last;
      if (pending_bus_writes.size() == 0) begin
        $display("%0t: unexpected write: is_data=%0b byte=%02h last=%0b", $time,
                 seen_write.is_data, seen_write.byte_value, seen_write.last);
        fail_count++;
      end else begin
        want_write = pending_bus_writes.pop_front();
        if (seen_write.is_data !== want_write.is_data ||
            seen_write.byte_value !== want_write.byte_value ||
            seen_write.last !== want_write.last) begin
          $display({"%0t: write mismatch: expected is_data=%0b byte=%02h last=%0b,",
                    " actual is_data=%0b byte=%02h last=%0b"},
                   $time, want_write.is_data, want_write.byte_value, want_write.last,
                   seen_write.is_data, seen_write.byte_value, seen_write.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d writes outstanding", $time,
               cycle_count, pending_bus_writes.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked requests: field extremes, every mode, and every wrap case of
  // the cursor. Gaps and stalls are on so even these see back-pressure.
  task automatic test_directed();
    src_gap_pct    = 25;
    sink_stall_pct = 25;
    send_request(ltcg_pkg::MODE_PUT, 8'h41, 3'd7, 1'b1);     // printable, other fields ignored
    send_request(ltcg_pkg::MODE_PUT, 8'h00, 3'd0, 1'b0);     // lowest byte still prints
    send_request(ltcg_pkg::MODE_PUT, 8'hFF, 3'd5, 1'b1);     // highest byte
    send_request(ltcg_pkg::MODE_SET, 8'hFF, 3'd7, 1'b0);     // last column of row 0
    send_request(ltcg_pkg::MODE_PUT, 8'h78, 3'd0, 1'b0);     // fills the row, moves to row 1
    send_request(ltcg_pkg::MODE_SET, ltcg_pkg::CHAR_BS, 3'd7, 1'b1); // last cell of display
    send_request(ltcg_pkg::MODE_PUT, 8'h79, 3'd2, 1'b0);     // fills the display, back to 0,0
    send_request(ltcg_pkg::MODE_PUT, ltcg_pkg::CHAR_BS, 3'd0, 1'b0); // first cell to last
    send_request(ltcg_pkg::MODE_PUT, ltcg_pkg::CHAR_BS, 3'd3, 1'b1); // plain step back
    send_request(ltcg_pkg::MODE_SET, 8'h00, 3'd0, 1'b1);     // start of row 1
    send_request(ltcg_pkg::MODE_PUT, ltcg_pkg::CHAR_BS, 3'd0, 1'b0); // back to end of row 0
    send_request(ltcg_pkg::MODE_PUT, ltcg_pkg::CHAR_LF, 3'd0, 1'b0); // row 0 to row 1
    send_request(ltcg_pkg::MODE_PUT, ltcg_pkg::CHAR_LF, 3'd7, 1'b1); // last row wraps to 0
    send_request(ltcg_pkg::MODE_SET, ltcg_pkg::CHAR_LF, 3'd5, 1'b1);
    send_request(ltcg_pkg::MODE_PUT, ltcg_pkg::CHAR_CR, 3'd0, 1'b0); // column 0, same row
    send_request(ltcg_pkg::MODE_PUT, ltcg_pkg::CHAR_CR, 3'd0, 1'b0); // return at column 0
    send_request(ltcg_pkg::MODE_SET, 8'h55, 3'd3, 1'b1);
    send_request(ltcg_pkg::MODE_CLEAR, 8'hAA, 3'd7, 1'b1);   // clear from a moved cursor
    send_request(ltcg_pkg::MODE_PUT, 8'h7E, 3'd0, 1'b0);
    send_request(ltcg_pkg::MODE_HOME, ltcg_pkg::CHAR_CR, 3'd4, 1'b0); // home, moved cursor
    send_request(ltcg_pkg::MODE_HOME, 8'hFF, 3'd0, 1'b1);    // home at 0,0
    send_request(ltcg_pkg::MODE_CLEAR, 8'h00, 3'd0, 1'b0);   // clear at 0,0
    send_request(ltcg_pkg::MODE_SET, 8'h00, 3'd0, 1'b0);     // lowest set target
  endtask

  // Running text: mostly put requests, so the cursor walks the whole display
  // and keeps wrapping, with the odd cursor move, clear or home mixed in.
  task automatic test_running_text(input int count);
    int pick;
    src_gap_pct    = 30;
    sink_stall_pct = 30;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        send_request(ltcg_pkg::MODE_PUT, text_char(), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        send_request(ltcg_pkg::MODE_SET, 8'($urandom_range(0, 255)),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else if (pick < 98) begin
        send_request(ltcg_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        send_request(ltcg_pkg::MODE_HOME, 8'($urandom_range(0, 255)),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Fully random requests under heavy result stalls, which keeps the output
  // queue full and the request side waiting on ready.
  task automatic test_random_requests(input int count);
    src_gap_pct    = 15;
    sink_stall_pct = 45;
    for (int i = 0; i < count; i++) begin
      send_any_request();
    end
  endtask

  // Full rate on both sides: valid stays high and ready never drops, so a
  // two-write request has to hold off the next transfer by itself.
  task automatic test_full_rate(input int count);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_request(ltcg_pkg::MODE_PUT, text_char(), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
      end else begin
        send_any_request();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    fail_count     = 0;
    cycle_count    = 0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    cursor_col     = '0;
    cursor_row     = '0;

    // Every input starts at a known value, with reset held low before release.
    rst_ni        = 1'b0;
    req.valid     <= 1'b0;
    req.mode      <= ltcg_pkg::MODE_PUT;
    req.char_code <= '0;
    req.column    <= '0;
    req.row       <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_running_text(600);
    test_random_requests(500);
    test_full_rate(350);

    // Stop offering requests, let every predicted write come out, then keep
    // clocking the block to catch any write that should not exist.
    req.valid <= 1'b0;
    while (pending_bus_writes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
